// ===== design/lbrs_pkg.sv =====
// ============================================================================
// lbrs_pkg: shared types and constants of the link bandwidth rate smoother
// ----------------------------------------------------------------------------
// Field widths, divider sizing, smoothing constants, register map and the
// state type of the top-level sequencer.
// ============================================================================
package lbrs_pkg;

    // Field widths.
    localparam int DATA_W     = 64;
    localparam int RATE_W     = 32;
    localparam int SMOOTH_W   = 18;

    // Only the low COUNTER_BITS bits of a counter sample take part.
    localparam int COUNTER_BITS = 64;
    localparam logic [DATA_W-1:0] COUNTER_MASK = {DATA_W{1'b1}} >> (DATA_W - COUNTER_BITS);

    // Cycle to nanosecond scaling: ns = (dt * 10) / 33, done four bits a cycle.
    localparam int              NS_REM_W   = 6;
    localparam logic [NS_REM_W:0] NS_DIV   = 7'd33;
    localparam int              NS_DIGIT   = 4;
    localparam int              NS_STEPS   = DATA_W / NS_DIGIT;
    localparam int              NS_CNT_W   = $clog2(NS_STEPS);

    // Rate divider: divisor is ns >> DIV_SHIFT, one quotient bit a cycle.
    localparam int DIV_SHIFT  = 5;
    localparam int DIVISOR_W  = DATA_W - DIV_SHIFT;
    localparam int RD_CNT_W   = $clog2(DATA_W);

    // Smoothing: s = (255*s + (rate << 10)) >> 8 for rates below the limit.
    localparam logic [RATE_W-1:0] RATE_LIMIT = 32'd150;
    localparam int EWMA_SHIFT       = 8;
    localparam int RATE_SCALE_SHIFT = 10;
    localparam int EWMA_SUM_W       = SMOOTH_W + EWMA_SHIFT + 1;

    // Configuration port.
    localparam int PADDR_W = 3;
    localparam int PDATA_W = 32;
    localparam logic [PADDR_W-3:0] REG_DIRECTION = 1'b0;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIFF,
        ST_SCALE,
        ST_NSDIV,
        ST_RDIV,
        ST_EWMA,
        ST_WB
    } lbrs_state_t;

endpackage

// ===== design/lbrs_if.sv =====
// ============================================================================
// lbrs_if: valid/ready channels of the link bandwidth rate smoother
// ----------------------------------------------------------------------------
// lbrs_smp_if carries one counter sample, lbrs_res_if one result.
// ============================================================================
interface lbrs_smp_if;
    logic                        valid;
    logic                        ready;
    logic [lbrs_pkg::DATA_W-1:0] counter_sample;
    logic [lbrs_pkg::DATA_W-1:0] timestamp;

    modport source (output valid, output counter_sample, output timestamp, input ready);
    modport sink   (input valid, input counter_sample, input timestamp, output ready);
endinterface

interface lbrs_res_if;
    logic                          valid;
    logic                          ready;
    logic [lbrs_pkg::DATA_W-1:0]   elapsed_ns;
    logic [lbrs_pkg::RATE_W-1:0]   rate;
    logic                          rate_valid;
    logic [lbrs_pkg::SMOOTH_W-1:0] smoothed_rate;
    logic                          smoothed_updated;

    modport source (output valid, output elapsed_ns, output rate, output rate_valid,
                    output smoothed_rate, output smoothed_updated, input ready);
    modport sink   (input valid, input elapsed_ns, input rate, input rate_valid,
                    input smoothed_rate, input smoothed_updated, output ready);
endinterface

// ===== design/link_bandwidth_rate_smoother.sv =====
// ============================================================================
// link_bandwidth_rate_smoother: traffic counter rate estimator with EWMA
// ----------------------------------------------------------------------------
// Turns successive samples of a cumulative traffic counter and a cycle
// timestamp into an elapsed time in nanoseconds, an instantaneous rate and
// a smoothed rate per traffic direction.
//
//   channel  kind        direction  carries
//   -------  ----------  ---------  ------------------------------------------
//   smp      valid/ready  in        counter_sample, timestamp
//   res      valid/ready  out       elapsed_ns, rate, rate_valid,
//                                   smoothed_rate, smoothed_updated
//   apb      psel/penable in/out    direction register at byte address 0
//
// One sample is in flight at a time. From its transfer on smp to its result
// being loaded into the output register, a sample passes through the
// differences, the divider start, the divide-by-33 unit (sixteen four-bit
// steps), the bit-serial rate divider (64 steps), the smoothing step and the
// write-back; the two dividers dominate. When the interval is too short to
// give a nonzero divisor the rate divider and the smoothing step are skipped.
// The next sample can transfer in the cycle after the load. The output
// register lets the next sample transfer while a result still waits on res;
// a stalled res holds the sequencer only in its last state. Reset is
// asynchronous and clears the timestamps, counters, smoothed rates and
// direction to zero; no clearing pass is needed.
// ============================================================================
module link_bandwidth_rate_smoother (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lbrs_pkg::PADDR_W-1:0]  paddr,
    input  logic [lbrs_pkg::PDATA_W-1:0]  pwdata,
    output logic [lbrs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    lbrs_smp_if.sink                      smp,
    lbrs_res_if.source                    res
);

    // Configuration.
    logic direction;

    // Sequencer.
    lbrs_pkg::lbrs_state_t state_reg;
    lbrs_pkg::lbrs_state_t state_next;
    logic ns_start;
    logic rd_start;
    logic load_res;

    // Architectural state, reset to zero.
    logic [lbrs_pkg::DATA_W-1:0]   last_ts_reg;
    logic [lbrs_pkg::DATA_W-1:0]   last_in_reg;
    logic [lbrs_pkg::DATA_W-1:0]   last_out_reg;
    logic [lbrs_pkg::SMOOTH_W-1:0] smooth_in_reg;
    logic [lbrs_pkg::SMOOTH_W-1:0] smooth_out_reg;

    // Per-sample working registers.
    logic [lbrs_pkg::DATA_W-1:0]   count_reg;
    logic [lbrs_pkg::DATA_W-1:0]   ts_reg;
    logic [lbrs_pkg::DATA_W-1:0]   dt_reg;
    logic [lbrs_pkg::DATA_W-1:0]   delta_reg;
    logic [lbrs_pkg::DATA_W-1:0]   ns_reg;
    logic [lbrs_pkg::RATE_W-1:0]   rate_reg;
    logic                          rate_valid_reg;
    logic                          updated_reg;

    // Output register.
    logic                          res_valid_reg;
    logic [lbrs_pkg::DATA_W-1:0]   res_ns_reg;
    logic [lbrs_pkg::RATE_W-1:0]   res_rate_reg;
    logic                          res_rate_valid_reg;
    logic [lbrs_pkg::SMOOTH_W-1:0] res_smooth_reg;
    logic                          res_updated_reg;

    // Datapath nets.
    logic [lbrs_pkg::DATA_W-1:0]     last_sel;
    logic [lbrs_pkg::SMOOTH_W-1:0]   smooth_sel;
    logic [lbrs_pkg::DATA_W-1:0]     scaled_dt;
    logic                            ns_done;
    logic [lbrs_pkg::DATA_W-1:0]     ns_q;
    logic [lbrs_pkg::DIVISOR_W-1:0]  divisor;
    logic                            rd_done;
    logic [lbrs_pkg::RATE_W-1:0]     rd_q;
    logic [lbrs_pkg::EWMA_SUM_W-1:0] ewma_sum;
    logic [lbrs_pkg::SMOOTH_W-1:0]   ewma_new;
    logic                            below_limit;

    lbrs_apb u_apb (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .direction (direction)
    );

    assign last_sel   = direction ? last_out_reg : last_in_reg;
    assign smooth_sel = direction ? smooth_out_reg : smooth_in_reg;

    // dt * 10 modulo 2^64 as two shifted copies.
    assign scaled_dt = (dt_reg << 3) + (dt_reg << 1);

    lbrs_ns_div u_ns_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (ns_start),
        .dividend (scaled_dt),
        .done     (ns_done),
        .quotient (ns_q)
    );

    assign divisor = ns_q[lbrs_pkg::DATA_W-1:lbrs_pkg::DIV_SHIFT];

    lbrs_rate_div u_rate_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (rd_start),
        .dividend (delta_reg),
        .divisor  (divisor),
        .done     (rd_done),
        .quotient (rd_q)
    );

    // Smoothing step: 255*s is s*256 - s. The rate is below 150 whenever this
    // is used, so its low eight bits carry all of it.
    assign ewma_sum = {1'b0, smooth_sel, {lbrs_pkg::EWMA_SHIFT{1'b0}}}
                    - {{(lbrs_pkg::EWMA_SHIFT+1){1'b0}}, smooth_sel}
                    + {{(lbrs_pkg::EWMA_SUM_W-8-lbrs_pkg::RATE_SCALE_SHIFT){1'b0}},
                       rate_reg[7:0], {lbrs_pkg::RATE_SCALE_SHIFT{1'b0}}};
    assign ewma_new    = ewma_sum[lbrs_pkg::EWMA_SHIFT +: lbrs_pkg::SMOOTH_W];
    assign below_limit = (rate_reg < lbrs_pkg::RATE_LIMIT);

    // Next state and control strobes.
    always_comb
    begin
        state_next = state_reg;
        ns_start   = 1'b0;
        rd_start   = 1'b0;
        load_res   = 1'b0;
        case (state_reg)
            lbrs_pkg::ST_IDLE:
            begin
                if (smp.valid)
                begin
                    state_next = lbrs_pkg::ST_DIFF;
                end
            end
            lbrs_pkg::ST_DIFF:
            begin
                state_next = lbrs_pkg::ST_SCALE;
            end
            lbrs_pkg::ST_SCALE:
            begin
                ns_start   = 1'b1;
                state_next = lbrs_pkg::ST_NSDIV;
            end
            lbrs_pkg::ST_NSDIV:
            begin
                if (ns_done)
                begin
                    // A short interval gives a zero divisor; the division
                    // and the smoothing step are skipped.
                    if (divisor != '0)
                    begin
                        rd_start   = 1'b1;
                        state_next = lbrs_pkg::ST_RDIV;
                    end
                    else
                    begin
                        state_next = lbrs_pkg::ST_WB;
                    end
                end
            end
            lbrs_pkg::ST_RDIV:
            begin
                if (rd_done)
                begin
                    state_next = lbrs_pkg::ST_EWMA;
                end
            end
            lbrs_pkg::ST_EWMA:
            begin
                state_next = lbrs_pkg::ST_WB;
            end
            lbrs_pkg::ST_WB:
            begin
                if (!res_valid_reg || res.ready)
                begin
                    load_res   = 1'b1;
                    state_next = lbrs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = lbrs_pkg::ST_IDLE;
            end
        endcase
    end

    assign smp.ready = (state_reg == lbrs_pkg::ST_IDLE);

    // Control and architectural state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= lbrs_pkg::ST_IDLE;
            res_valid_reg  <= 1'b0;
            last_ts_reg    <= '0;
            last_in_reg    <= '0;
            last_out_reg   <= '0;
            smooth_in_reg  <= '0;
            smooth_out_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;

            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res.ready)
            begin
                res_valid_reg <= 1'b0;
            end

            // The new timestamp and count are recorded whether or not a rate
            // comes out of this sample.
            if (state_reg == lbrs_pkg::ST_DIFF)
            begin
                last_ts_reg <= ts_reg;
                if (direction)
                begin
                    last_out_reg <= count_reg;
                end
                else
                begin
                    last_in_reg <= count_reg;
                end
            end

            if (state_reg == lbrs_pkg::ST_EWMA && below_limit)
            begin
                if (direction)
                begin
                    smooth_out_reg <= ewma_new;
                end
                else
                begin
                    smooth_in_reg <= ewma_new;
                end
            end
        end
    end

    // Per-sample datapath registers.
    always_ff @(posedge clk)
    begin
        if (smp.valid && smp.ready)
        begin
            count_reg <= smp.counter_sample & lbrs_pkg::COUNTER_MASK;
            ts_reg    <= smp.timestamp;
        end

        if (state_reg == lbrs_pkg::ST_DIFF)
        begin
            dt_reg    <= ts_reg - last_ts_reg;
            delta_reg <= (count_reg - last_sel) & lbrs_pkg::COUNTER_MASK;
        end

        if (state_reg == lbrs_pkg::ST_NSDIV && ns_done)
        begin
            ns_reg         <= ns_q;
            rate_reg       <= '0;
            rate_valid_reg <= (divisor != '0);
            updated_reg    <= 1'b0;
        end

        if (state_reg == lbrs_pkg::ST_RDIV && rd_done)
        begin
            rate_reg <= rd_q;
        end

        if (state_reg == lbrs_pkg::ST_EWMA)
        begin
            updated_reg <= below_limit;
        end

        if (load_res)
        begin
            res_ns_reg         <= ns_reg;
            res_rate_reg       <= rate_reg;
            res_rate_valid_reg <= rate_valid_reg;
            res_smooth_reg     <= smooth_sel;
            res_updated_reg    <= updated_reg;
        end
    end

    assign res.valid            = res_valid_reg;
    assign res.elapsed_ns       = res_ns_reg;
    assign res.rate             = res_rate_reg;
    assign res.rate_valid       = res_rate_valid_reg;
    assign res.smoothed_rate    = res_smooth_reg;
    assign res.smoothed_updated = res_updated_reg;

endmodule

// ===== design/lbrs_apb.sv =====
// ============================================================================
// lbrs_apb: configuration register block
// ----------------------------------------------------------------------------
// Holds the direction select. Writes land on the access cycle; pready is
// tied high.
// ============================================================================
module lbrs_apb (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [lbrs_pkg::PADDR_W-1:0]  paddr,
    input  logic [lbrs_pkg::PDATA_W-1:0]  pwdata,
    output logic [lbrs_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready,
    output logic                          direction
);

    logic direction_reg;
    logic direction_next;
    logic sel_direction;

    assign sel_direction = (paddr[lbrs_pkg::PADDR_W-1:2] == lbrs_pkg::REG_DIRECTION);

    always_comb
    begin
        direction_next = direction_reg;
        if (psel && penable && pwrite && sel_direction)
        begin
            direction_next = pwdata[0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= 1'b0;
        end
        else
        begin
            direction_reg <= direction_next;
        end
    end

    assign prdata    = sel_direction ? {{(lbrs_pkg::PDATA_W-1){1'b0}}, direction_reg} : '0;
    assign pready    = 1'b1;
    assign direction = direction_reg;

endmodule

// ===== design/lbrs_ns_div.sv =====
// ============================================================================
// lbrs_ns_div: divide-by-33 unit
// ----------------------------------------------------------------------------
// Long division by the constant 33, four dividend bits per cycle, with a
// six-bit partial remainder. Quotient replaces the dividend in place.
// ============================================================================
module lbrs_ns_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [lbrs_pkg::DATA_W-1:0]  dividend,
    output logic                         done,
    output logic [lbrs_pkg::DATA_W-1:0]  quotient
);

    logic                              busy_reg;
    logic                              busy_next;
    logic                              done_reg;
    logic                              done_next;
    logic [lbrs_pkg::NS_CNT_W-1:0]     cnt_reg;
    logic [lbrs_pkg::NS_CNT_W-1:0]     cnt_next;
    logic [lbrs_pkg::DATA_W-1:0]       acc_reg;
    logic [lbrs_pkg::DATA_W-1:0]       acc_next;
    logic [lbrs_pkg::NS_REM_W-1:0]     rem_reg;
    logic [lbrs_pkg::NS_REM_W-1:0]     rem_next;

    // Four restoring steps on narrow values per cycle.
    always_comb
    begin
        logic [lbrs_pkg::NS_REM_W:0]   trial;
        logic [lbrs_pkg::NS_REM_W-1:0] r;
        logic [lbrs_pkg::NS_DIGIT-1:0] q;
        r     = rem_reg;
        q     = '0;
        trial = '0;
        for (int k = 0; k < lbrs_pkg::NS_DIGIT; k++)
        begin
            trial = {r, acc_reg[lbrs_pkg::DATA_W-1-k]};
            if (trial >= lbrs_pkg::NS_DIV)
            begin
                q[lbrs_pkg::NS_DIGIT-1-k] = 1'b1;
                r = lbrs_pkg::NS_REM_W'(trial - lbrs_pkg::NS_DIV);
            end
            else
            begin
                r = trial[lbrs_pkg::NS_REM_W-1:0];
            end
        end
        rem_next = r;
        acc_next = {acc_reg[lbrs_pkg::DATA_W-lbrs_pkg::NS_DIGIT-1:0], q};
    end

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = lbrs_pkg::NS_CNT_W'(lbrs_pkg::NS_STEPS - 1);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= dividend;
            rem_reg <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg;

endmodule

// ===== design/lbrs_rate_div.sv =====
// ============================================================================
// lbrs_rate_div: bit-serial rate divider
// ----------------------------------------------------------------------------
// Restoring division of the 64-bit counter delta by the 59-bit scaled
// interval, one quotient bit per cycle. Only the low 32 quotient bits leave.
// ============================================================================
module lbrs_rate_div (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic [lbrs_pkg::DATA_W-1:0]     dividend,
    input  logic [lbrs_pkg::DIVISOR_W-1:0]  divisor,
    output logic                            done,
    output logic [lbrs_pkg::RATE_W-1:0]     quotient
);

    logic                               busy_reg;
    logic                               busy_next;
    logic                               done_reg;
    logic                               done_next;
    logic [lbrs_pkg::RD_CNT_W-1:0]      cnt_reg;
    logic [lbrs_pkg::RD_CNT_W-1:0]      cnt_next;
    logic [lbrs_pkg::DATA_W-1:0]        acc_reg;
    logic [lbrs_pkg::DATA_W-1:0]        acc_next;
    logic [lbrs_pkg::DIVISOR_W-1:0]     rem_reg;
    logic [lbrs_pkg::DIVISOR_W-1:0]     rem_next;
    logic [lbrs_pkg::DIVISOR_W-1:0]     dvs_reg;
    logic [lbrs_pkg::DIVISOR_W:0]       trial;
    logic [lbrs_pkg::DIVISOR_W:0]       diff;
    logic                               ge;

    assign trial    = {rem_reg, acc_reg[lbrs_pkg::DATA_W-1]};
    assign diff     = trial - {1'b0, dvs_reg};
    assign ge       = (trial >= {1'b0, dvs_reg});
    assign rem_next = ge ? diff[lbrs_pkg::DIVISOR_W-1:0] : trial[lbrs_pkg::DIVISOR_W-1:0];
    assign acc_next = {acc_reg[lbrs_pkg::DATA_W-2:0], ge};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = lbrs_pkg::RD_CNT_W'(lbrs_pkg::DATA_W - 1);
        end
        else if (busy_reg)
        begin
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= acc_next;
            rem_reg <= rem_next;
        end
    end

    assign done     = done_reg;
    assign quotient = acc_reg[lbrs_pkg::RATE_W-1:0];

endmodule

// ===== design/lbrs_chk.sv =====
// ============================================================================
// lbrs_chk: port-level checker for the link bandwidth rate smoother
// ----------------------------------------------------------------------------
// Watches the sample and result channels and flags results that break the
// block's rules. Bound to the top level below.
// ============================================================================
module lbrs_chk (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          smp_valid,
    input logic                          smp_ready,
    input logic                          res_valid,
    input logic                          res_ready,
    input logic [lbrs_pkg::DATA_W-1:0]   res_elapsed_ns,
    input logic [lbrs_pkg::RATE_W-1:0]   res_rate,
    input logic                          res_rate_valid,
    input logic [lbrs_pkg::SMOOTH_W-1:0] res_smoothed_rate,
    input logic                          res_smoothed_updated
);

    // A stalled result stays valid and keeps its elapsed time, rate and smoothed rate unchanged.
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_elapsed_ns)
            && $stable(res_rate) && $stable(res_smoothed_rate))
        else $error("stalled result changed");

    // Without a divisor the rate reads as zero.
    a_rate_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_rate_valid |-> res_rate == '0)
        else $error("rate nonzero while rate_valid is low");

    // Smoothing only follows a valid rate below the limit.
    a_upd_rule: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_smoothed_updated |->
            res_rate_valid && res_rate < lbrs_pkg::RATE_LIMIT)
        else $error("smoothing update without a valid small rate");

    // One sample at a time: the channel closes right after a transfer.
    a_one_sample: assert property (@(posedge clk) disable iff (!rst_n)
        smp_valid && smp_ready |=> !smp_ready)
        else $error("sample accepted while one is in flight");

endmodule

bind link_bandwidth_rate_smoother lbrs_chk u_lbrs_chk (
    .clk                  (clk),
    .rst_n                (rst_n),
    .smp_valid            (smp.valid),
    .smp_ready            (smp.ready),
    .res_valid            (res.valid),
    .res_ready            (res.ready),
    .res_elapsed_ns       (res.elapsed_ns),
    .res_rate             (res.rate),
    .res_rate_valid       (res.rate_valid),
    .res_smoothed_rate    (res.smoothed_rate),
    .res_smoothed_updated (res.smoothed_updated)
);
